// File: rtl/triangle_counter_defines.svh
// Assertion macros used by the checker file of the triangle counter.
`ifndef TRIANGLE_COUNTER_DEFINES_SVH
`define TRIANGLE_COUNTER_DEFINES_SVH

// Same-cycle implication, sampled on clk and quiet while rst_n is low.
`define TRIC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and quiet while rst_n is low.
`define TRIC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/tric_pkg.sv
`timescale 1ns / 1ps

package tric_pkg;

    // Largest graph the adjacency store holds.
    localparam int MAX_VERTICES = 64;
    // Width of a vertex number and of the vertex count register.
    localparam int VTX_W = 7;
    // Vertex counters with one spare bit for bound compares.
    localparam int EXT_W = VTX_W + 1;
    // Row address width of the adjacency store.
    localparam int ADDR_W = $clog2(MAX_VERTICES);
    // Population count of one half row.
    localparam int HALF_W = MAX_VERTICES / 2;
    localparam int PC_W = $clog2(HALF_W + 1);
    // Result width and its saturation value.
    localparam int CNT_W = 16;
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
    // Input payload width: two vertex numbers rounded up to whole bytes.
    localparam int S_DATA_W = ((2 * VTX_W + 7) / 8) * 8;

    typedef logic [MAX_VERTICES-1:0] row_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic              edge_wr;   // an edge transfer is taken this cycle
        logic              clr_acc;   // start a new count
        logic              rd_en;     // read one adjacency row
        logic [ADDR_W-1:0] rd_addr;
        logic              latch_i;   // hold the row just read as the pivot row
        logic              scan;      // the row read this cycle is a partner row
        logic              finish;    // publish the result and clear the graph
    } tric_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic             busy;       // partner rows still in the pipeline
        logic             out_free;   // output register can take a result
        logic [VTX_W-1:0] eff_n;      // vertex count limited to MAX_VERTICES
    } tric_sts_t;

    // Columns strictly above column j.
    function automatic row_t mask_above(input logic [ADDR_W-1:0] j);
        logic [VTX_W-1:0] amt;
        amt = VTX_W'(j) + VTX_W'(1);
        return {MAX_VERTICES{1'b1}} << amt;
    endfunction

    // Columns below n; all columns when n equals MAX_VERTICES.
    function automatic row_t mask_below(input logic [VTX_W-1:0] n);
        return ~({MAX_VERTICES{1'b1}} << n);
    endfunction

    function automatic logic [PC_W-1:0] popcount_half(input logic [HALF_W-1:0] v);
        logic [PC_W-1:0] sum;
        sum = '0;
        for (int b = 0; b < HALF_W; b++)
        begin
            sum = sum + PC_W'(v[b]);
        end
        return sum;
    endfunction

endpackage

// File: rtl/tric_ctrl.sv
`timescale 1ns / 1ps

module tric_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    input  logic                s_tlast,
    output logic                s_tready,
    input  tric_pkg::tric_sts_t sts,
    output tric_pkg::tric_cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_I_START,
        ST_I_LATCH,
        ST_J_SCAN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    state_t                     state_reg;
    logic [tric_pkg::VTX_W-1:0] i_reg;
    logic [tric_pkg::VTX_W-1:0] j_reg;
    logic                       take;
    logic                       no_pair;
    logic                       j_end;

    assign s_tready = (state_reg == ST_LOAD);
    assign take     = s_tvalid && s_tready;

    // Row i has no pair j<k above it once i+2 reaches n.
    assign no_pair = (tric_pkg::EXT_W'(i_reg) + tric_pkg::EXT_W'(2))
                     >= tric_pkg::EXT_W'(sts.eff_n);
    assign j_end   = (tric_pkg::VTX_W'(j_reg + tric_pkg::VTX_W'(1)) == sts.eff_n);

    always_comb
    begin
        cmd         = '0;
        cmd.edge_wr = take;
        cmd.clr_acc = take && s_tlast;
        case (state_reg)
            ST_I_START:
            begin
                cmd.rd_en   = !no_pair;
                cmd.rd_addr = i_reg[tric_pkg::ADDR_W-1:0];
            end
            ST_I_LATCH:
            begin
                cmd.latch_i = 1'b1;
            end
            ST_J_SCAN:
            begin
                cmd.rd_en   = 1'b1;
                cmd.rd_addr = j_reg[tric_pkg::ADDR_W-1:0];
                cmd.scan    = 1'b1;
            end
            ST_FINISH:
            begin
                cmd.finish = sts.out_free;
            end
            default:
            begin
                cmd.rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            i_reg     <= '0;
            j_reg     <= '0;
        end
        else
        begin
            case (state_reg)
                ST_LOAD:
                begin
                    if (take && s_tlast)
                    begin
                        i_reg     <= '0;
                        state_reg <= ST_I_START;
                    end
                end
                ST_I_START:
                begin
                    if (no_pair)
                    begin
                        state_reg <= ST_DRAIN;
                    end
                    else
                    begin
                        j_reg     <= i_reg + tric_pkg::VTX_W'(1);
                        state_reg <= ST_I_LATCH;
                    end
                end
                ST_I_LATCH:
                begin
                    state_reg <= ST_J_SCAN;
                end
                ST_J_SCAN:
                begin
                    if (j_end)
                    begin
                        i_reg     <= i_reg + tric_pkg::VTX_W'(1);
                        state_reg <= ST_I_START;
                    end
                    else
                    begin
                        j_reg <= j_reg + tric_pkg::VTX_W'(1);
                    end
                end
                ST_DRAIN:
                begin
                    if (!sts.busy)
                    begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH:
                begin
                    if (sts.out_free)
                    begin
                        state_reg <= ST_LOAD;
                    end
                end
                default:
                begin
                    state_reg <= ST_LOAD;
                end
            endcase
        end
    end

endmodule

// File: rtl/tric_dp.sv
`timescale 1ns / 1ps

module tric_dp (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [tric_pkg::VTX_W-1:0]     vertex_count,
    input  logic [tric_pkg::VTX_W-1:0]     edge_first,
    input  logic [tric_pkg::VTX_W-1:0]     edge_second,
    input  tric_pkg::tric_cmd_t            cmd,
    output tric_pkg::tric_sts_t            sts,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [tric_pkg::CNT_W-1:0]     triangle_count,
    output logic                           bad_edge_seen
);

    localparam int AW = tric_pkg::ADDR_W;
    localparam int HW = tric_pkg::HALF_W;
    localparam int NV = tric_pkg::MAX_VERTICES;

    // Upper-triangle adjacency store: row min(a,b)-1 holds bit max(a,b)-1.
    tric_pkg::row_t                 mem [NV];
    logic [NV-1:0]                  row_vld_reg;
    tric_pkg::row_t                 rd_data_reg;
    logic                           rd_ok_reg;
    tric_pkg::row_t                 rd_row;

    logic [tric_pkg::VTX_W-1:0]     eff_n;
    logic                           bad;
    logic [tric_pkg::VTX_W-1:0]     lo_v;
    logic [tric_pkg::VTX_W-1:0]     hi_v;
    logic                           wr_en;
    logic [AW-1:0]                  wr_row;
    logic [AW-1:0]                  wr_col;
    logic                           bad_flag_reg;

    tric_pkg::row_t                 row_i_reg;
    logic                           s1_vld_reg;
    logic [AW-1:0]                  s1_j_reg;
    logic                           s2_vld_reg;
    tric_pkg::row_t                 s2_and_reg;
    logic                           s3_vld_reg;
    logic [tric_pkg::PC_W-1:0]      s3_lo_reg;
    logic [tric_pkg::PC_W-1:0]      s3_hi_reg;
    logic [tric_pkg::CNT_W-1:0]     acc_reg;
    logic [tric_pkg::CNT_W:0]       acc_sum;
    tric_pkg::row_t                 and_next;

    assign eff_n = (vertex_count > tric_pkg::VTX_W'(NV)) ? tric_pkg::VTX_W'(NV)
                                                         : vertex_count;

    assign bad = (edge_first == '0) || (edge_second == '0)
              || (edge_first > eff_n) || (edge_second > eff_n);
    assign lo_v   = (edge_first < edge_second) ? edge_first : edge_second;
    assign hi_v   = (edge_first < edge_second) ? edge_second : edge_first;
    // Self-loops never close a triangle, so they are not stored.
    assign wr_en  = cmd.edge_wr && !bad && (edge_first != edge_second);
    assign wr_row = AW'(lo_v - tric_pkg::VTX_W'(1));
    assign wr_col = AW'(hi_v - tric_pkg::VTX_W'(1));

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            if (row_vld_reg[wr_row])
            begin
                mem[wr_row][wr_col] <= 1'b1;
            end
            else
            begin
                mem[wr_row] <= tric_pkg::row_t'(1) << wr_col;
            end
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[cmd.rd_addr];
        end
    end

    // A row never written since the last clear reads as zero.
    assign rd_row = rd_ok_reg ? rd_data_reg : '0;

    assign and_next = (rd_row & row_i_reg & tric_pkg::mask_above(s1_j_reg)
                       & tric_pkg::mask_below(eff_n))
                      & {NV{row_i_reg[s1_j_reg]}};

    always_ff @(posedge clk)
    begin
        if (cmd.latch_i)
        begin
            row_i_reg <= rd_row;
        end
        s1_j_reg   <= cmd.rd_addr;
        s2_and_reg <= and_next;
        s3_lo_reg  <= tric_pkg::popcount_half(s2_and_reg[HW-1:0]);
        s3_hi_reg  <= tric_pkg::popcount_half(s2_and_reg[NV-1:HW]);
    end

    assign acc_sum = (tric_pkg::CNT_W+1)'(acc_reg) + (tric_pkg::CNT_W+1)'(s3_lo_reg)
                   + (tric_pkg::CNT_W+1)'(s3_hi_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_vld_reg    <= '0;
            rd_ok_reg      <= 1'b0;
            bad_flag_reg   <= 1'b0;
            s1_vld_reg     <= 1'b0;
            s2_vld_reg     <= 1'b0;
            s3_vld_reg     <= 1'b0;
            acc_reg        <= '0;
            m_tvalid       <= 1'b0;
            triangle_count <= '0;
            bad_edge_seen  <= 1'b0;
        end
        else
        begin
            if (cmd.rd_en)
            begin
                rd_ok_reg <= row_vld_reg[cmd.rd_addr];
            end
            s1_vld_reg <= cmd.scan;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;

            if (cmd.clr_acc)
            begin
                acc_reg <= '0;
            end
            else if (s3_vld_reg)
            begin
                acc_reg <= acc_sum[tric_pkg::CNT_W] ? tric_pkg::CNT_MAX
                                                    : acc_sum[tric_pkg::CNT_W-1:0];
            end

            if (cmd.finish)
            begin
                row_vld_reg  <= '0;
                bad_flag_reg <= 1'b0;
            end
            else
            begin
                if (wr_en)
                begin
                    row_vld_reg[wr_row] <= 1'b1;
                end
                if (cmd.edge_wr && bad)
                begin
                    bad_flag_reg <= 1'b1;
                end
            end

            if (cmd.finish)
            begin
                m_tvalid       <= 1'b1;
                triangle_count <= acc_reg;
                bad_edge_seen  <= bad_flag_reg;
            end
            else if (m_tready)
            begin
                m_tvalid <= 1'b0;
            end
        end
    end

    assign sts.busy     = s1_vld_reg || s2_vld_reg || s3_vld_reg;
    assign sts.out_free = !m_tvalid || m_tready;
    assign sts.eff_n    = eff_n;

endmodule

// File: rtl/triangle_counter.sv
`timescale 1ns / 1ps

// Triangle counter. Edges of an undirected graph stream in on the s_ side, one
// transfer per cycle while the block is loading, each holding two 1-based
// vertex numbers; tlast marks the final edge. Each valid edge other than a
// self-loop sets a bit in a 64 x 64 adjacency store, while an edge naming vertex
// 0 or a vertex above vertex_count capped at 64 is dropped and flagged. After
// the last edge the block stops taking transfers and counts the distinct
// triangles among vertices 1..n, where n is vertex_count capped at 64. The count
// walks the store one row pair per cycle through its single read port: each
// pivot row i is fetched and latched, then each partner row j above it is read
// and matched against it, and a pipeline drain and a result step close the
// pass. The last cycle of the pass is held for as long as an earlier result
// still waits on the m_ side. The result then leaves on the m_ side as a single
// transfer, and the store and the bad-edge flag are cleared at once through
// per-row valid bits, so loading the next graph can start in the following
// cycle even while that result still waits.
module triangle_counter (
    input  logic        clk,
    input  logic        rst_n,
    // Edge input.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [6:0] edge_first, [13:7] edge_second, [15:14] zero
    input  logic        s_tlast,   // is_last
    // Result output.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] triangle_count
    output logic        m_tuser,   // [0] bad_edge_seen
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic REG_VERTEX_COUNT = 1'b0;

    logic [tric_pkg::VTX_W-1:0] vertex_count_reg;
    tric_pkg::tric_cmd_t        cmd;
    tric_pkg::tric_sts_t        sts;

    // Only vertex_count exists; its word sits at byte address zero.
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vertex_count_reg <= tric_pkg::VTX_W'(tric_pkg::MAX_VERTICES);
        end
        else if (psel && penable && pwrite && pready && (paddr[2] == REG_VERTEX_COUNT))
        begin
            vertex_count_reg <= pwdata[tric_pkg::VTX_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_VERTEX_COUNT) ? 32'(vertex_count_reg) : '0;

    tric_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    tric_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .vertex_count   (vertex_count_reg),
        .edge_first     (s_tdata[tric_pkg::VTX_W-1:0]),
        .edge_second    (s_tdata[2*tric_pkg::VTX_W-1:tric_pkg::VTX_W]),
        .cmd            (cmd),
        .sts            (sts),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .triangle_count (m_tdata),
        .bad_edge_seen  (m_tuser)
    );

endmodule

// File: rtl/tric_checker.sv
`timescale 1ns / 1ps
`include "triangle_counter_defines.svh"

module tric_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tuser
);

    // A waiting result keeps its value until it is taken.
    `TRIC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

    // The last edge of a graph starts the count, so input closes right after it.
    `TRIC_ASSERT_NEXT(a_count_stalls, s_tvalid && s_tready && s_tlast, !s_tready, "input open after last edge")

    // A new result only appears at the end of a counting pass.
    `TRIC_ASSERT_NOW(a_result_after_count, $rose(m_tvalid), $past(!s_tready), "result without a count")

    // No graph of 64 vertices has more triangles than C(64,3).
    `TRIC_ASSERT_NOW(a_count_range, m_tvalid, m_tdata <= 16'd41664, "triangle count out of range")

endmodule

bind triangle_counter tric_checker u_tric_checker (.*);

// File: dv/tb_triangle_counter.sv
`timescale 1ns / 1ps

// Testbench for the triangle counter. Edges are streamed into the block as
// graphs, and each graph ends with a transfer that carries tlast. A scoreboard
// keeps its own copy of the adjacency matrix, the bad-edge flag and the vertex
// count. On the last edge of a graph it counts the triangles and queues the
// result that the block must return. Every result transfer is then checked,
// field by field, against the oldest queued result.
module tb_triangle_counter;

    // Register map of the configuration port.
    localparam logic [2:0] VERTEX_COUNT_ADDR = 3'd0;

    // Cycles granted after the last result before the register is touched, so
    // that the block has plainly returned to loading edges.
    localparam int SETTLE_CYCLES = 16;
    // Quiet cycles at the end of the run, so that a stray result is caught.
    localparam int TAIL_CYCLES = 50;
    // Length of the run in the random part, counted in edge transfers per phase.
    localparam int PHASE_EDGES = 165;

    // One result of the block: the triangle count and the bad-edge flag.
    typedef struct {
        logic [tric_pkg::CNT_W-1:0] tri_count;
        logic                       bad_seen;
    } tally_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;   // [6:0] edge_first, [13:7] edge_second, [15:14] zero
    logic        s_tlast;   // is_last
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // [15:0] triangle_count
    logic        m_tuser;   // [0] bad_edge_seen
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Scoreboard state: the graph as loaded so far, the bad-edge flag and the
    // vertex count register as the block should see it.
    tric_pkg::row_t             graph_rows [tric_pkg::MAX_VERTICES];
    logic                       graph_bad;
    logic [tric_pkg::VTX_W-1:0] vtx_limit;
    tally_t                     expected_tallies [$];
    int                         fail_count;

    // Sender idle chance per edge; share of cycles in which the receiver stalls.
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;

    triangle_counter u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // A generous fixed limit. Even a run in which every edge closes a graph of
    // 64 vertices, with the receiver stalling half the time, stays far below it.
    initial
    begin
        #600_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // The receiver drops tready at random, at the rate of the current phase.
    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // ------------------------------------------------------------------
    // Scoreboard
    // ------------------------------------------------------------------

    // A vertex count above the size of the store acts as the full size.
    function automatic int unsigned active_vertices();
        return (vtx_limit > tric_pkg::MAX_VERTICES) ? tric_pkg::MAX_VERTICES
                                                    : int'(vtx_limit);
    endfunction

    // Counts each triple i < j < k among the active vertices that is fully
    // connected. The count saturates, which a 64-vertex graph never reaches.
    function automatic logic [tric_pkg::CNT_W-1:0] tally_triangles();
        int unsigned    n;
        int unsigned    total;
        tric_pkg::row_t common;
        n = active_vertices();
        total = 0;
        for (int i = 0; i < n; i++)
        begin
            for (int j = i + 1; j < n; j++)
            begin
                if (graph_rows[i][j])
                begin
                    common = graph_rows[i] & graph_rows[j];
                    for (int k = j + 1; k < n; k++)
                    begin
                        if (common[k] && total < tric_pkg::CNT_MAX)
                        begin
                            total++;
                        end
                    end
                end
            end
        end
        return tric_pkg::CNT_W'(total);
    endfunction

    // Applies one accepted edge. An endpoint of zero or above the vertex count
    // only raises the flag. A self-loop sets a diagonal bit, which no triangle
    // uses. On the last edge the result is queued and the graph is cleared.
    task automatic absorb_edge(input logic [tric_pkg::VTX_W-1:0] first,
                               input logic [tric_pkg::VTX_W-1:0] second,
                               input logic last);
        int unsigned n;
        int          ia;
        int          ib;
        tally_t      tally;
        n = active_vertices();
        ia = int'(first) - 1;
        ib = int'(second) - 1;
        if (first == 0 || second == 0 || first > n || second > n)
        begin
            graph_bad = 1'b1;
        end
        else
        begin
            graph_rows[ia][ib] = 1'b1;
            graph_rows[ib][ia] = 1'b1;
        end
        if (last)
        begin
            tally.tri_count = tally_triangles();
            tally.bad_seen = graph_bad;
            expected_tallies = {expected_tallies, tally};
            foreach (graph_rows[r])
            begin
                graph_rows[r] = '0;
            end
            graph_bad = 1'b0;
        end
    endtask

    // Results are checked first, then register writes and edges are applied.
    // A result never shares a clock edge with the edge that caused it.
    always @(posedge clk)
    begin : scoreboard
        tally_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_tallies.size() == 0)
                begin
                    $error("result with no expected result: triangle_count %0d, bad_edge_seen %0d",
                           m_tdata, m_tuser);
                    fail_count++;
                end
                else
                begin
                    want = expected_tallies.pop_front();
                    if (m_tdata !== want.tri_count)
                    begin
                        $error("triangle_count mismatch: expected %0d, actual %0d",
                               want.tri_count, m_tdata);
                        fail_count++;
                    end
                    if (m_tuser !== want.bad_seen)
                    begin
                        $error("bad_edge_seen mismatch: expected %0d, actual %0d",
                               want.bad_seen, m_tuser);
                        fail_count++;
                    end
                end
            end
            if (psel && penable && pwrite && pready && paddr == VERTEX_COUNT_ADDR)
            begin
                vtx_limit = pwdata[tric_pkg::VTX_W-1:0];
            end
            if (s_tvalid && s_tready)
            begin
                absorb_edge(s_tdata[6:0], s_tdata[13:7], s_tlast);
            end
        end
    end

    // ------------------------------------------------------------------
    // Drivers. Every task is entered and left at a falling clock edge.
    // ------------------------------------------------------------------

    // Sends one edge transfer. The sender may first idle, and tvalid stays high
    // from one transfer to the next when it does not.
    task automatic send_edge(input int unsigned first, input int unsigned second,
                             input bit last);
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {2'b00, 7'(second), 7'(first)};
        s_tlast <= last;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
    endtask

    // Holds the sender back until every queued result has arrived, and then
    // lets the block settle.
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (expected_tallies.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Writes the vertex count register once the block is idle.
    task automatic set_vertex_count(input int unsigned count);
        wait_for_results();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= VERTEX_COUNT_ADDR;
        pwdata <= 32'(count);
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // The vertex count comes out of reset at 64. A complete graph on the four
    // highest vertices holds four triangles.
    task automatic test_reset_vertex_count();
        send_edge(61, 62, 0);
        send_edge(62, 63, 0);
        send_edge(61, 63, 0);
        send_edge(63, 64, 0);
        send_edge(64, 61, 0);
        send_edge(62, 64, 1);
    endtask

    // One triangle among an endpoint of zero, a self-loop, a duplicate edge
    // given in the reverse order and an endpoint at the top of the field.
    task automatic test_edge_cases();
        send_edge(0, 5, 0);
        send_edge(1, 1, 0);
        send_edge(1, 2, 0);
        send_edge(2, 1, 0);
        send_edge(2, 3, 0);
        send_edge(127, 3, 0);
        send_edge(1, 3, 1);
    endtask

    // An oversized count acts as 64, so vertex 64 is valid and 65 is not. A
    // count of zero rejects every edge, and a count of one allows only the
    // self-loop on vertex 1.
    task automatic test_vertex_count_limits();
        set_vertex_count(127);
        send_edge(65, 2, 0);
        send_edge(64, 1, 0);
        send_edge(1, 2, 0);
        send_edge(64, 2, 1);
        set_vertex_count(0);
        send_edge(1, 2, 1);
        set_vertex_count(1);
        send_edge(1, 1, 1);
    endtask

    // The count shrinks while a graph is loaded. Edges already taken stay,
    // later ones are checked against the new count, and the triangle on
    // vertices 8, 9 and 10 falls outside the vertices that are counted.
    task automatic test_resize_mid_graph();
        set_vertex_count(10);
        send_edge(8, 9, 0);
        send_edge(9, 10, 0);
        send_edge(10, 8, 0);
        set_vertex_count(9);
        send_edge(10, 1, 0);
        send_edge(7, 8, 1);
    endtask

    // Mostly small graphs, since the counting pass grows with the square of the
    // vertex count. The extremes still turn up now and then.
    function automatic int unsigned pick_vertex_count();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 8)
        begin
            return $urandom_range(0, 2);
        end
        else if (r < 14)
        begin
            return tric_pkg::MAX_VERTICES;
        end
        else if (r < 20)
        begin
            return $urandom_range(tric_pkg::MAX_VERTICES + 1, 127);
        end
        else if (r < 35)
        begin
            return $urandom_range(13, 40);
        end
        return $urandom_range(3, 12);
    endfunction

    // One graph. Most edges fall within a cluster of up to six vertices, so
    // triangles are common. The rest are spread over all vertices, sit just
    // past the vertex count or at vertex zero, or are arbitrary values of the field.
    task automatic send_random_graph(output int unsigned edge_count);
        int unsigned eff;
        int unsigned span;
        int unsigned base;
        int unsigned r;
        int unsigned a;
        int unsigned b;
        eff = active_vertices();
        edge_count = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 40) : $urandom_range(1, 20);
        span = (eff < 6) ? eff : 6;
        base = (eff > span) ? $urandom_range(1, eff - span + 1) : 1;
        for (int e = 0; e < edge_count; e++)
        begin
            r = $urandom_range(0, 99);
            if (eff == 0 || r < 12)
            begin
                a = $urandom_range(0, 127);
                b = $urandom_range(0, 127);
            end
            else if (r < 20)
            begin
                a = $urandom_range(1, eff);
                b = (r < 15) ? 0 : eff + $urandom_range(1, 3);
                if ($urandom_range(0, 1))
                begin
                    {a, b} = {b, a};
                end
            end
            else if (r < 45)
            begin
                a = $urandom_range(1, eff);
                b = $urandom_range(1, eff);
            end
            else
            begin
                a = base + $urandom_range(0, span - 1);
                b = base + $urandom_range(0, span - 1);
            end
            send_edge(a, b, e == edge_count - 1);
        end
    endtask

    // One idling phase: graphs follow each other back to back, and now and
    // then the sender waits for every result and sets a new vertex count.
    task automatic run_phase(input int unsigned idle_pct, input int unsigned stall_pct);
        int unsigned sent;
        int unsigned graph_edges;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        sent = 0;
        set_vertex_count(pick_vertex_count());
        while (sent < PHASE_EDGES)
        begin
            if ($urandom_range(0, 99) < 30)
            begin
                set_vertex_count(pick_vertex_count());
            end
            send_random_graph(graph_edges);
            sent += graph_edges;
        end
    endtask

    task automatic test_random_graphs();
        run_phase(0, 0);
        run_phase(54, 0);
        run_phase(0, 54);
        run_phase(13, 13);
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        m_tready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        fail_count = 0;
        graph_bad = 1'b0;
        vtx_limit = tric_pkg::VTX_W'(tric_pkg::MAX_VERTICES);
        foreach (graph_rows[r])
        begin
            graph_rows[r] = '0;
        end
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_vertex_count();
        test_edge_cases();
        test_vertex_count_limits();
        test_resize_mid_graph();
        test_random_graphs();

        wait_for_results();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (fail_count == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
